// ===== src/hsr_pkg.sv =====
// ---------------------------------------------------------------------------
// hsr_pkg - shared constants for the Heron square root block
// Field widths, parameter defaults and the guess ceiling used by the top
// level and the shared divider.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package hsr_pkg;

  // Field widths
  localparam int VALUE_W = 32;   // signed input number
  localparam int GUESS_W = 31;   // guess, root and divisor width
  localparam int TOL_W   = 31;   // tolerance register width

  // Parameter defaults
  localparam int MAX_ITER_DEF  = 32;
  localparam int FRAC_BITS_DEF = 16;

  // Largest legal guess (2^31 - 1)
  localparam logic [GUESS_W-1:0] GUESS_MAX = {GUESS_W{1'b1}};

  // Tolerance after reset
  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(1);

endpackage

// ===== src/heron_square_root.sv =====
// ---------------------------------------------------------------------------
// heron_square_root - fixed-point square root by Heron's iteration
// A negative or zero number goes straight to the result beat; otherwise
//   each step runs the bit-serial divider, updates and squares the guess and
//   checks it against the tolerance, at Q16.16 by default, with steps between 1 and MAX_ITERATIONS.
// One number at a time; the next beat is taken once the result is parked
//   in the output register. Reset: synchronous, active low; tolerance is 1.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module heron_square_root #(
  parameter int MAX_ITERATIONS = hsr_pkg::MAX_ITER_DEF,
  parameter int FRACTION_BITS  = hsr_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // Configuration
  input  logic                        cfg_we,
  input  logic [hsr_pkg::TOL_W-1:0]   cfg_wdata,    // tolerance
  // Input stream
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [hsr_pkg::VALUE_W-1:0] in_tdata,     // [31:0] value_in
  // Result stream
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [31:0]                 out_tdata,    // [30:0] root, [31] zero
  output logic [1:0]                  out_tuser     // [0] negative_error, [1] limit_reached
);

  localparam int GW   = hsr_pkg::GUESS_W;
  localparam int QW   = GW + FRACTION_BITS;          // quotient width
  localparam int PW   = 2 * GW;                      // product width
  localparam int SQW  = PW - FRACTION_BITS;          // rescaled square width
  localparam int CMPW = SQW + 1;
  localparam int SW   = $clog2(MAX_ITERATIONS + 1);

  // Sequencer codes
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LD   = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_UPD  = 3'd3;
  localparam logic [2:0] S_SQR  = 3'd4;
  localparam logic [2:0] S_CHK  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0]                 state_r, state_nxt;
  logic [hsr_pkg::TOL_W-1:0]  tol_r;
  logic [GW-1:0]              x_r, x_nxt;
  logic [GW-1:0]              guess_r, guess_nxt;
  logic [PW-1:0]              prod_r;
  logic [SW-1:0]              step_r, step_nxt;
  logic [GW-1:0]              res_root_r, res_root_nxt;
  logic                       res_neg_r, res_neg_nxt;
  logic                       res_lim_r, res_lim_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [GW-1:0]              out_root_r;
  logic                       out_neg_r, out_lim_r;

  logic                       in_beat, out_load;
  logic                       div_start, div_done;
  logic [QW-1:0]              quo;
  logic [QW:0]                sum;
  logic [QW-1:0]              mean;
  logic [GW-1:0]              mean_clamped;
  logic [GW-2:0]              half;
  logic [SQW-1:0]             sq;
  logic                       met;
  logic [SW-1:0]              step_inc;

  // Shared divider: (x << FRACTION_BITS) / guess
  hsr_div #(
    .FRAC_BITS (FRACTION_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .numer    (x_r),
    .divisor  (guess_r),
    .done     (div_done),
    .quotient (quo)
  );

  assign in_tready = (state_r == S_IDLE);
  assign in_beat   = in_tvalid && in_tready;
  assign div_start = (state_r == S_LD);
  assign out_load  = (state_r == S_FIN) && (!out_valid_r || out_tready);

  // Truncated mean of guess and quotient, held inside 1 .. 2^31-1
  always_comb begin
    sum  = {1'b0, QW'(guess_r)} + {1'b0, quo};
    mean = sum[QW:1];
    if (mean == '0) begin
      mean_clamped = GW'(1);
    end else if (mean[QW-1:GW] != '0) begin
      mean_clamped = hsr_pkg::GUESS_MAX;
    end else begin
      mean_clamped = mean[GW-1:0];
    end
  end

  // Tolerance check on the rescaled square
  always_comb begin
    sq  = prod_r[PW-1:FRACTION_BITS];
    met = (CMPW'(sq) <= CMPW'(x_r) + CMPW'(tol_r)) &&
          (CMPW'(sq) + CMPW'(tol_r) >= CMPW'(x_r));
    step_inc = step_r + SW'(1);
  end

  assign half = in_tdata[GW-1:1];

  // Sequencer
  always_comb begin
    state_nxt    = state_r;
    x_nxt        = x_r;
    guess_nxt    = guess_r;
    step_nxt     = step_r;
    res_root_nxt = res_root_r;
    res_neg_nxt  = res_neg_r;
    res_lim_nxt  = res_lim_r;
    case (state_r)
      S_IDLE: begin
        if (in_beat) begin
          x_nxt        = in_tdata[GW-1:0];
          step_nxt     = '0;
          res_root_nxt = '0;
          res_neg_nxt  = in_tdata[hsr_pkg::VALUE_W-1];
          res_lim_nxt  = 1'b0;
          guess_nxt    = (half == '0) ? GW'(1) : {1'b0, half};
          if (in_tdata[hsr_pkg::VALUE_W-1] || (in_tdata == '0)) begin
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_LD;
          end
        end
      end
      S_LD: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        guess_nxt = mean_clamped;
        state_nxt = S_SQR;
      end
      S_SQR: begin
        state_nxt = S_CHK;
      end
      S_CHK: begin
        step_nxt = step_inc;
        if (met || (step_inc == SW'(MAX_ITERATIONS))) begin
          res_root_nxt = guess_r;
          res_lim_nxt  = !met;
          state_nxt    = S_FIN;
        end else begin
          state_nxt = S_LD;
        end
      end
      S_FIN: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Drop the result beat once taken, raise it on load
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tol_r       <= hsr_pkg::TOL_RESET;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        tol_r <= cfg_wdata;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    guess_r    <= guess_nxt;
    prod_r     <= PW'(guess_r) * PW'(guess_r);
    res_root_r <= res_root_nxt;
    res_neg_r  <= res_neg_nxt;
    res_lim_r  <= res_lim_nxt;
    if (out_load) begin
      out_root_r <= res_root_r;
      out_neg_r  <= res_neg_r;
      out_lim_r  <= res_lim_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_root_r};
  assign out_tuser  = {out_lim_r, out_neg_r};

endmodule

// ===== src/hsr_div.sv =====
// ---------------------------------------------------------------------------
// hsr_div - restoring divider, one quotient bit per cycle
// Divides x << FRAC_BITS by the current guess. The divisor must hold
// steady while the division runs; done is high for a single cycle, together with the last quotient bit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module hsr_div #(
  parameter int FRAC_BITS = hsr_pkg::FRAC_BITS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      start,
  input  logic [hsr_pkg::GUESS_W-1:0]               numer,    // x, before the shift
  input  logic [hsr_pkg::GUESS_W-1:0]               divisor,
  output logic                                      done,
  output logic [hsr_pkg::GUESS_W+FRAC_BITS-1:0]     quotient
);

  localparam int GW = hsr_pkg::GUESS_W;
  localparam int DW = GW + FRAC_BITS;
  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] dq_r, dq_nxt;      // dividend bits out at the top, quotient bits in
  logic [GW-1:0] rem_r, rem_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          done_r, done_nxt;

  logic [GW:0]   rem_sh;
  logic          fits;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    rem_sh  = {rem_r, dq_r[DW-1]};
    fits    = (rem_sh >= {1'b0, divisor});
    rem_nxt = rem_r;
    dq_nxt  = dq_r;
    cnt_nxt = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt = '0;
      dq_nxt  = {numer, {FRAC_BITS{1'b0}}};
      cnt_nxt = CW'(DW);
    end else if (cnt_r != '0) begin
      rem_nxt  = fits ? GW'(rem_sh - {1'b0, divisor}) : GW'(rem_sh);
      dq_nxt   = {dq_r[DW-2:0], fits};
      cnt_nxt  = cnt_r - CW'(1);
      done_nxt = (cnt_r == CW'(1));
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dq_r  <= dq_nxt;
  end

  assign done     = done_r;
  assign quotient = dq_r;

endmodule

// ===== test/heron_square_root_test.sv =====
// ---------------------------------------------------------------------------
// heron_square_root_test - self-checking bench for the Heron square root
// Sends signed Q16.16 numbers into heron_square_root and checks each root
// and its error and limit flags against a bit-true Heron predictor. A short
// table of corner numbers comes first, followed by random numbers under
// several tolerance settings and three source/sink idling mixes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module heron_square_root_test;

  localparam int STEP_CAP      = hsr_pkg::MAX_ITER_DEF;
  localparam int FRAC          = hsr_pkg::FRAC_BITS_DEF;
  localparam int TOL_W         = hsr_pkg::TOL_W;
  localparam int BLOCK_ITEMS   = 66;        // random numbers per tolerance setting
  localparam int SETTLE_CYCLES = 2000;      // longer than a capped iteration
  localparam int CYCLE_LIMIT   = 8000000;
  localparam int REPORT_MAX    = 10;

  localparam logic [hsr_pkg::TOL_W-1:0]   TOL_TOP   = {hsr_pkg::TOL_W{1'b1}};
  localparam logic [hsr_pkg::GUESS_W-1:0] GUESS_TOP = hsr_pkg::GUESS_MAX;
  // Largest root whose rescaled square still fits a positive input
  localparam int unsigned ROOT_FIT = 32'h00B5_04F3;

  typedef struct packed {
    logic [hsr_pkg::GUESS_W-1:0] root;
    logic                        negative_error;
    logic                        limit_reached;
  } root_beat_t;

  typedef struct packed {
    logic [hsr_pkg::VALUE_W-1:0] value;
    logic                        typed;   // want holds a hand-written result
    root_beat_t                  want;
  } probe_row_t;

  localparam root_beat_t ZERO_ROOT = '{root: '0, negative_error: 1'b0, limit_reached: 1'b0};
  localparam root_beat_t NEG_ROOT  = '{root: '0, negative_error: 1'b1, limit_reached: 1'b0};
  localparam root_beat_t PREDICT   = '0;

  localparam int PROBE_N = 20;

  // Corner numbers, run at the tolerance left by reset
  probe_row_t probe_rows [PROBE_N] = '{
    '{32'h0000_0000, 1'b1, ZERO_ROOT},   // zero
    '{32'hFFFF_FFFF, 1'b1, NEG_ROOT},    // smallest negative step
    '{32'h8000_0000, 1'b1, NEG_ROOT},    // most negative
    '{32'hC000_0000, 1'b1, NEG_ROOT},
    '{32'h0000_0001, 1'b0, PREDICT},     // halved value is zero, first guess held at 1
    '{32'h0000_0002, 1'b0, PREDICT},
    '{32'h0000_0003, 1'b0, PREDICT},
    '{32'h7FFF_FFFF, 1'b0, PREDICT},     // largest positive
    '{32'h0001_0000, 1'b0, PREDICT},     // 1.0
    '{32'h0004_0000, 1'b0, PREDICT},     // 4.0
    '{32'h0000_8000, 1'b0, PREDICT},     // 0.5
    '{32'h0064_0000, 1'b0, PREDICT},     // 100.0
    '{32'h4000_0000, 1'b0, PREDICT},
    '{32'h5555_5555, 1'b0, PREDICT},
    '{32'h2AAA_AAAA, 1'b0, PREDICT},
    '{32'h7FFF_0000, 1'b0, PREDICT},
    '{32'h0000_0100, 1'b0, PREDICT},
    '{32'h0000_FFFF, 1'b0, PREDICT},
    '{32'h0000_0000, 1'b1, ZERO_ROOT},   // zero after a real root
    '{32'h8000_0001, 1'b1, NEG_ROOT}
  };

  logic                        clk;
  logic                        rst_n      = 1'b0;
  logic                        cfg_we     = 1'b0;
  logic [hsr_pkg::TOL_W-1:0]   cfg_wdata  = '0;
  logic                        in_tvalid  = 1'b0;
  logic                        in_tready;
  logic [hsr_pkg::VALUE_W-1:0] in_tdata   = '0;   // [31:0] value_in
  logic                        out_tvalid;
  logic                        out_tready = 1'b0;
  logic [31:0]                 out_tdata;         // [30:0] root, [31] zero
  logic [1:0]                  out_tuser;         // [0] negative_error, [1] limit_reached

  // Predictor state and tolerance shadow
  logic [hsr_pkg::TOL_W-1:0] tol_shadow = hsr_pkg::TOL_RESET;
  logic [31:0]               guess_shadow = '0;
  logic [6:0]                steps_shadow = '0;

  root_beat_t pending_roots [$];
  int         mismatch_count = 0;
  int         cycle_count    = 0;
  int         src_idle_pct   = 0;
  int         sink_idle_pct  = 0;

  heron_square_root #(
    .MAX_ITERATIONS (STEP_CAP),
    .FRACTION_BITS  (FRAC)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Guess is never zero and never above the 31-bit ceiling
  function automatic logic [63:0] bound_guess(input logic [63:0] g);
    if (g == 64'd0) begin
      return 64'd1;
    end
    if (g > 64'(GUESS_TOP)) begin
      return 64'(GUESS_TOP);
    end
    return g;
  endfunction

  // Run Heron's iteration on one number and return the expected result beat
  function automatic root_beat_t heron_predict(input logic [31:0] raw);
    root_beat_t    r;
    logic [63:0]   x;
    logic [63:0]   g;
    logic [63:0]   q;
    logic [63:0]   sq;
    longint        gap;
    longint        tol;
    int            steps;
    bit            met;
    r     = '0;
    steps = 0;
    met   = 1'b0;
    if (raw[31]) begin
      r.negative_error = 1'b1;
      guess_shadow     = '0;
      steps_shadow     = '0;
      return r;
    end
    if (raw == '0) begin
      guess_shadow = '0;
      steps_shadow = '0;
      return r;
    end
    x   = 64'(raw);
    tol = longint'(tol_shadow);
    g   = bound_guess(x >> 1);
    while (steps < STEP_CAP && !met) begin
      q = (x << FRAC) / g;
      g = bound_guess((g + q) >> 1);
      steps++;
      sq  = (g * g) >> FRAC;
      gap = longint'(sq) - longint'(x);
      if (gap <= tol && gap >= -tol) begin
        met = 1'b1;
      end
    end
    guess_shadow    = g[31:0];
    steps_shadow    = steps[6:0];
    r.root          = g[hsr_pkg::GUESS_W-1:0];
    r.limit_reached = !met;
    return r;
  endfunction

  // Mostly positive numbers, with negatives, tiny values and near-squares mixed in
  function automatic logic [31:0] pick_value();
    int          sel;
    logic [63:0] r;
    sel = $urandom_range(0, 99);
    if (sel < 15) begin
      return $urandom | 32'h8000_0000;
    end
    if (sel < 20) begin
      return $urandom_range(0, 3);
    end
    if (sel < 35) begin
      return $urandom_range(1, 32'h0003_FFFF);
    end
    if (sel < 50) begin
      r = 64'($urandom_range(1, ROOT_FIT));
      return 32'((r * r) >> FRAC) & 32'h7FFF_FFFF;
    end
    return $urandom & 32'h7FFF_FFFF;
  endfunction

  // Present one beat, idling at random first; valid stays high on return
  task automatic push_value(input logic [31:0] v);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Send a number and queue what it should return
  task automatic send_and_expect(input logic [31:0] v, input logic typed,
                                 input root_beat_t want);
    root_beat_t predicted;
    push_value(v);
    predicted = heron_predict(v);
    pending_roots.push_back(typed ? want : predicted);
  endtask

  // Drop valid and wait for every queued root to come back
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_roots.size() != 0) @(posedge clk);
  endtask

  task automatic set_tolerance(input logic [hsr_pkg::TOL_W-1:0] tol);
    cfg_we    <= 1'b1;
    cfg_wdata <= tol;
    @(posedge clk);
    cfg_we     <= 1'b0;
    tol_shadow  = tol;
  endtask

  // Stimulus
  initial begin : stimulus
    int                        src_mix  [3];
    int                        sink_mix [3];
    logic [hsr_pkg::TOL_W-1:0] tol_set  [5];
    src_mix  = '{24, 54, 0};
    sink_mix = '{54, 24, 0};

    src_idle_pct  = src_mix[0];
    sink_idle_pct = sink_mix[0];
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (probe_rows[i]) begin
      send_and_expect(probe_rows[i].value, probe_rows[i].typed, probe_rows[i].want);
    end
    drain();

    for (int mix = 0; mix < 3; mix++) begin
      src_idle_pct  = src_mix[mix];
      sink_idle_pct = sink_mix[mix];
      tol_set = '{TOL_TOP, TOL_W'($urandom_range(1, TOL_TOP)),
                  TOL_W'($urandom_range(2, 4095)), '0, 31'd1};
      foreach (tol_set[t]) begin
        set_tolerance(tol_set[t]);
        repeat (BLOCK_ITEMS) send_and_expect(pick_value(), 1'b0, PREDICT);
        drain();
      end
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Sink: stall at random
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk) begin : check_results
    root_beat_t want;
    root_beat_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.root           = out_tdata[hsr_pkg::GUESS_W-1:0];
      got.negative_error = out_tuser[0];
      got.limit_reached  = out_tuser[1];
      if (pending_roots.size() == 0) begin
        if (mismatch_count < REPORT_MAX) begin
          $display("%0t: unexpected beat root=%h neg=%b lim=%b",
                   $realtime, got.root, got.negative_error, got.limit_reached);
        end
        mismatch_count++;
      end else begin
        want = pending_roots.pop_front();
        if (got != want || out_tdata[31] !== 1'b0) begin
          if (mismatch_count < REPORT_MAX) begin
            $display("%0t: root mismatch exp root=%h neg=%b lim=%b got root=%h neg=%b lim=%b pad=%b",
                     $realtime, want.root, want.negative_error, want.limit_reached,
                     got.root, got.negative_error, got.limit_reached, out_tdata[31]);
          end
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

endmodule
